>>> design/sstf_pkg.sv
// Shared types and codes of the shortest-seek-first request scheduler.
// Holds default sizes, operation and status codes, and controller/datapath structs.
// No dependencies.
package sstf_pkg;

    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_SECTOR_BITS = 48;
    localparam int DEF_TAG_BITS    = 8;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int PCOUNT_W = 6;

    localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
    localparam logic [OP_W-1:0] OP_DISPATCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd4;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } sstf_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } sstf_sts_t;

endpackage

>>> design/sstf_ctrl.sv
// Controller state machine of the request scheduler.
// Sequences accept, slot scan and commit; depends on sstf_pkg.
module sstf_ctrl
    import sstf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  sstf_sts_t sts,
    output sstf_cmd_t cmd
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        COMMIT
    } state_t;

    state_t state_reg;

    assign s_tready   = (state_reg == IDLE);
    assign cmd.load   = s_tvalid && (state_reg == IDLE);
    assign cmd.scan   = (state_reg == SCAN);
    assign cmd.commit = (state_reg == COMMIT) && sts.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            case (state_reg)
                IDLE: begin
                    if (s_tvalid) state_reg <= SCAN;
                end
                SCAN: begin
                    if (sts.scan_done) state_reg <= COMMIT;
                end
                COMMIT: begin
                    if (sts.out_free) state_reg <= IDLE;
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/sstf_datapath.sv
// Datapath of the request scheduler: slot memory, valid bits, head position,
// scan and slot selection (nearest, free or tag match), and the result register. Depends on sstf_pkg.
module sstf_datapath
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SECTOR_BITS = DEF_SECTOR_BITS,
    parameter int TAG_BITS    = DEF_TAG_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sstf_cmd_t              cmd,
    output sstf_sts_t              sts,
    input  logic [OP_W-1:0]        in_operation,
    input  logic [SECTOR_BITS-1:0] in_sector,
    input  logic [TAG_BITS-1:0]    in_tag,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [STATUS_W-1:0]    out_status,
    output logic [SECTOR_BITS-1:0] out_sector,
    output logic [TAG_BITS-1:0]    out_tag,
    output logic [PCOUNT_W-1:0]    out_count
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [SECTOR_BITS-1:0] mem_sector [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    mem_tag    [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_reg;

    logic [OP_W-1:0]        op_reg;
    logic [SECTOR_BITS-1:0] sec_reg;
    logic [TAG_BITS-1:0]    tag_reg;
    logic [SECTOR_BITS-1:0] head_reg;
    logic [CNT_W-1:0]       count_reg;

    logic [IDX_W:0]         rd_cnt_reg;
    logic                   ev_vld_reg;
    logic [IDX_W-1:0]       ev_idx_reg;
    logic                   ev_slot_reg;
    logic [SECTOR_BITS-1:0] rd_sec_reg;
    logic [TAG_BITS-1:0]    rd_tag_reg;

    logic                   found_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [SECTOR_BITS-1:0] best_dist_reg;
    logic [SECTOR_BITS-1:0] best_sec_reg;
    logic [TAG_BITS-1:0]    best_tag_reg;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [SECTOR_BITS-1:0] out_sector_reg;
    logic [TAG_BITS-1:0]    out_tag_reg;
    logic [PCOUNT_W-1:0]    out_count_reg;

    logic                   issue;
    logic [IDX_W-1:0]       rd_addr;
    logic [SECTOR_BITS-1:0] seek_dist;
    logic                   take;
    logic                   mem_wr;

    assign issue     = cmd.scan && (rd_cnt_reg != (IDX_W+1)'(QUEUE_DEPTH));
    assign rd_addr   = rd_cnt_reg[IDX_W-1:0];
    assign seek_dist = (rd_sec_reg >= head_reg) ? (rd_sec_reg - head_reg)
                                                : (head_reg - rd_sec_reg);

    always_comb begin
        take = 1'b0;
        if (ev_vld_reg) begin
            case (op_reg)
                OP_ADD:      take = !found_reg && !ev_slot_reg;
                OP_DISPATCH: take = ev_slot_reg && (!found_reg || (seek_dist < best_dist_reg));
                OP_REMOVE:   take = !found_reg && ev_slot_reg && (rd_tag_reg == tag_reg);
                default:     take = 1'b0;
            endcase
        end
    end

    assign mem_wr = cmd.commit && (op_reg == OP_ADD) && found_reg;

    assign sts.scan_done = (rd_cnt_reg == (IDX_W+1)'(QUEUE_DEPTH)) && !ev_vld_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            mem_sector[best_idx_reg] <= sec_reg;
            mem_tag[best_idx_reg]    <= tag_reg;
        end
        rd_sec_reg <= mem_sector[rd_addr];
        rd_tag_reg <= mem_tag[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_operation;
            sec_reg <= in_sector;
            tag_reg <= in_tag;
        end
        ev_idx_reg  <= rd_addr;
        ev_slot_reg <= valid_reg[rd_addr];
        if (take) begin
            best_idx_reg  <= ev_idx_reg;
            best_dist_reg <= seek_dist;
            best_sec_reg  <= rd_sec_reg;
            best_tag_reg  <= rd_tag_reg;
        end
        if (cmd.commit) begin
            out_sector_reg <= '0;
            out_tag_reg    <= '0;
            out_count_reg  <= PCOUNT_W'(count_reg);
            case (op_reg)
                OP_ADD: begin
                    if (found_reg) begin
                        out_status_reg <= ST_ADDED;
                        out_count_reg  <= PCOUNT_W'(count_reg + 1'b1);
                    end else begin
                        out_status_reg <= ST_FULL;
                    end
                end
                OP_DISPATCH: begin
                    if (found_reg) begin
                        out_status_reg <= ST_DISPATCHED;
                        out_sector_reg <= best_sec_reg;
                        out_tag_reg    <= best_tag_reg;
                        out_count_reg  <= PCOUNT_W'(count_reg - 1'b1);
                    end else begin
                        out_status_reg <= ST_EMPTY;
                    end
                end
                OP_REMOVE: begin
                    out_status_reg <= ST_REMOVED;
                    out_tag_reg    <= tag_reg;
                    if (found_reg) out_count_reg <= PCOUNT_W'(count_reg - 1'b1);
                end
                default: begin
                    out_status_reg <= ST_REMOVED;
                    out_tag_reg    <= tag_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            ev_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            ev_vld_reg <= issue;
            if (issue) rd_cnt_reg <= rd_cnt_reg + 1'b1;
            if (cmd.load) begin
                rd_cnt_reg <= '0;
                found_reg  <= 1'b0;
            end else if (take) begin
                found_reg <= 1'b1;
            end
            if (cmd.commit && found_reg) begin
                case (op_reg)
                    OP_ADD: begin
                        valid_reg[best_idx_reg] <= 1'b1;
                        count_reg               <= count_reg + 1'b1;
                    end
                    OP_DISPATCH: begin
                        valid_reg[best_idx_reg] <= 1'b0;
                        count_reg               <= count_reg - 1'b1;
                        head_reg                <= best_sec_reg;
                    end
                    OP_REMOVE: begin
                        valid_reg[best_idx_reg] <= 1'b0;
                        count_reg               <= count_reg - 1'b1;
                    end
                    default: begin
                        count_reg <= count_reg;
                    end
                endcase
            end
            if (cmd.commit) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_sector = out_sector_reg;
    assign out_tag    = out_tag_reg;
    assign out_count  = out_count_reg;

endmodule

>>> design/sstf_request_scheduler_top.sv
// Top level of the shortest-seek-first request scheduler.
// Instantiates sstf_ctrl and sstf_datapath; depends on sstf_pkg.
//
// Every request (add, dispatch, remove by tag) passes through accept, a scan
// that reads each slot in turn through the slot memory's single registered
// read port, a drain of the last read, and commit.
// One request is in work at a time; the result sits in an output register,
// and the commit waits while a previous result is still untaken. Ties in seek
// distance go to the lower slot; duplicate tags remove the lowest match.
module sstf_request_scheduler_top
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SECTOR_BITS = DEF_SECTOR_BITS,
    parameter int TAG_BITS    = DEF_TAG_BITS,
    localparam int IN_W  = ((OP_W + SECTOR_BITS + TAG_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((STATUS_W + SECTOR_BITS + TAG_BITS + PCOUNT_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // operation, request_sector, request_tag
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, served_sector, served_tag, pending_count
);

    sstf_cmd_t cmd;
    sstf_sts_t sts;

    logic [STATUS_W-1:0]    status;
    logic [SECTOR_BITS-1:0] served_sector;
    logic [TAG_BITS-1:0]    served_tag;
    logic [PCOUNT_W-1:0]    pending_count;

    sstf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sstf_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SECTOR_BITS (SECTOR_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .in_operation (s_tdata[OP_W-1:0]),
        .in_sector    (s_tdata[OP_W+SECTOR_BITS-1:OP_W]),
        .in_tag       (s_tdata[OP_W+SECTOR_BITS+TAG_BITS-1:OP_W+SECTOR_BITS]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_status   (status),
        .out_sector   (served_sector),
        .out_tag      (served_tag),
        .out_count    (pending_count)
    );

    assign m_tdata = OUT_W'({pending_count, served_tag, served_sector, status});

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("scheduler accepted a request while busy");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("commit overwrote an untaken result");

    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("result appeared without a commit");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(pending_count) <= 32'(QUEUE_DEPTH)))
        else $error("pending count exceeds queue depth");

endmodule
